// File: src/utf8_sequence_decode_core_defines.svh
// ----------------------------------------------------------------------------
// utf8 sequence decode core assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef UTF8_SEQUENCE_DECODE_CORE_DEFINES_SVH
`define UTF8_SEQUENCE_DECODE_CORE_DEFINES_SVH

// same-cycle implication
`define UTF8SD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UTF8SD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg
// types and constants shared by the utf8 sequence decode core
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int ADV_W    = 3;
    localparam int STATUS_W = 2;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [CP_W-1:0]     cp_t;
    typedef logic [ADV_W-1:0]    adv_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_END     = 2'd0;
    localparam status_t STATUS_DECODED = 2'd1;
    localparam status_t STATUS_RAW     = 2'd2;

    localparam byte_t LEAD_2B_MIN = 8'hC2;
    localparam byte_t LEAD_2B_MAX = 8'hDF;
    localparam byte_t LEAD_3B_MIN = 8'hE0;
    localparam byte_t LEAD_3B_MAX = 8'hEF;
    localparam byte_t LEAD_4B_MIN = 8'hF0;
    localparam byte_t LEAD_4B_MAX = 8'hF4;
    localparam byte_t LEAD_SURR   = 8'hED;
    localparam byte_t SURR_MASK   = 8'hA0;
    localparam byte_t MASK_2B     = 8'hE0;
    localparam byte_t MATCH_2B    = 8'hC0;
    localparam byte_t MASK_3B     = 8'hF0;
    localparam byte_t MATCH_3B    = 8'hE0;
    localparam byte_t MASK_4B     = 8'hF8;
    localparam byte_t MATCH_4B    = 8'hF0;
    localparam byte_t MASK_CONT   = 8'hC0;
    localparam byte_t MATCH_CONT  = 8'h80;

    typedef struct packed {
        byte_t lead_byte;
        byte_t second_byte;
        byte_t third_byte;
        byte_t fourth_byte;
    } window_t;

    typedef struct packed {
        cp_t     codepoint;
        adv_t    advance_width;
        status_t decode_status;
    } result_t;

endpackage

// File: src/utf8_sequence_decode_core.sv
// ----------------------------------------------------------------------------
// utf8_sequence_decode_core
// decodes one utf8 sequence window per word into codepoint, width and status
// ----------------------------------------------------------------------------
// Accepts one four-byte window per clock while the output is not stalled and
// returns one result word per window, in order. The window is captured in an
// input register, decoded by a single combinational pass, and captured in the
// result register. Sustained rate is one word per cycle while result_ready is
// held high; item_ready follows result_ready combinationally through both
// register stages.
// ----------------------------------------------------------------------------
`include "utf8_sequence_decode_core_defines.svh"

module utf8_sequence_decode_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  utf8sd_pkg::byte_t           lead_byte,
    input  utf8sd_pkg::byte_t           second_byte,
    input  utf8sd_pkg::byte_t           third_byte,
    input  utf8sd_pkg::byte_t           fourth_byte,
    output logic                        result_valid,
    input  logic                        result_ready,
    output utf8sd_pkg::cp_t             codepoint,
    output utf8sd_pkg::adv_t            advance_width,
    output utf8sd_pkg::status_t         decode_status
);
    import utf8sd_pkg::*;

    localparam int WIN_W = $bits(window_t);
    localparam int RES_W = $bits(result_t);

    window_t          win_in;
    window_t          win_q;
    logic [WIN_W-1:0] win_q_bits;
    logic             win_valid;
    logic             win_ready;
    result_t          dec_res;
    logic [RES_W-1:0] res_q_bits;
    result_t          res_q;

    assign win_in.lead_byte   = lead_byte;
    assign win_in.second_byte = second_byte;
    assign win_in.third_byte  = third_byte;
    assign win_in.fourth_byte = fourth_byte;

    utf8sd_stage #(
        .WIDTH (WIN_W)
    ) u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (item_valid),
        .up_ready (item_ready),
        .up_data  (win_in),
        .dn_valid (win_valid),
        .dn_ready (win_ready),
        .dn_data  (win_q_bits)
    );

    assign win_q = win_q_bits;

    utf8sd_decode u_decode (
        .win (win_q),
        .res (dec_res)
    );

    utf8sd_stage #(
        .WIDTH (RES_W)
    ) u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (win_valid),
        .up_ready (win_ready),
        .up_data  (dec_res),
        .dn_valid (result_valid),
        .dn_ready (result_ready),
        .dn_data  (res_q_bits)
    );

    assign res_q         = res_q_bits;
    assign codepoint     = res_q.codepoint;
    assign advance_width = res_q.advance_width;
    assign decode_status = res_q.decode_status;

    `UTF8SD_ASSERT_NXT(a_accept_fills_stage, item_valid && item_ready, win_valid,
        "accepted word did not reach the input register")
    `UTF8SD_ASSERT_NXT(a_stalled_window_holds, win_valid && !win_ready,
        win_valid && $stable(win_q_bits), "stalled window changed")
    `UTF8SD_ASSERT_IMP(a_end_result, result_valid && decode_status == STATUS_END,
        codepoint == '0 && advance_width == 3'd1, "bad end of text result")
    `UTF8SD_ASSERT_IMP(a_raw_is_byte, result_valid && decode_status == STATUS_RAW,
        codepoint[CP_W-1:BYTE_W] == '0, "raw pass-through wider than a byte")
    `UTF8SD_ASSERT_IMP(a_result_sane, result_valid,
        advance_width >= 3'd1 && advance_width <= 3'd4
        && decode_status <= STATUS_RAW, "result width or status out of range")

endmodule

// File: src/utf8sd_stage.sv
// ----------------------------------------------------------------------------
// utf8sd_stage
// one valid/ready register stage, accepts a new word every cycle while dn_ready is high
// ----------------------------------------------------------------------------
module utf8sd_stage #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  logic [WIDTH-1:0] up_data,
    output logic             dn_valid,
    input  logic             dn_ready,
    output logic [WIDTH-1:0] dn_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= up_data;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: src/utf8sd_decode.sv
// ----------------------------------------------------------------------------
// utf8sd_decode
// single-pass decode of one four-byte window into codepoint, width, status
// ----------------------------------------------------------------------------
module utf8sd_decode (
    input  utf8sd_pkg::window_t win,
    output utf8sd_pkg::result_t res
);
    import utf8sd_pkg::*;

    byte_t      b0, b1, b2, b3;
    logic [1:0] ew;
    logic [1:0] need;
    logic       lead_ok;
    logic       c1, c2, c3;
    logic       nz1, nz2, nz3;
    logic       seq_ok;
    adv_t       adv;
    cp_t        cp;

    assign b0 = win.lead_byte;
    assign b1 = win.second_byte;
    assign b2 = win.third_byte;
    assign b3 = win.fourth_byte;

    assign c1 = (b1 & MASK_CONT) == MATCH_CONT;
    assign c2 = (b2 & MASK_CONT) == MATCH_CONT;
    assign c3 = (b3 & MASK_CONT) == MATCH_CONT;

    assign nz1 = b1 != '0;
    assign nz2 = b2 != '0;
    assign nz3 = b3 != '0;

    // advance class
    always_comb
    begin
        if (b0 >= LEAD_2B_MIN && b0 <= LEAD_2B_MAX)
            ew = 2'd1;
        else if (b0 >= LEAD_3B_MIN && b0 <= LEAD_3B_MAX)
            ew = 2'd2;
        else if (b0 >= LEAD_4B_MIN && b0 <= LEAD_4B_MAX)
            ew = 2'd3;
        else
            ew = 2'd0;
    end

    assign adv = 3'd1
               + {2'b00, (ew >= 2'd1) && nz1}
               + {2'b00, (ew >= 2'd2) && nz1 && nz2}
               + {2'b00, (ew == 2'd3) && nz1 && nz2 && nz3};

    // validation class
    always_comb
    begin
        lead_ok = 1'b1;
        need    = 2'd0;
        if (!b0[7])
            need = 2'd0;
        else if ((b0 & MASK_2B) == MATCH_2B)
            need = 2'd1;
        else if (b0 == LEAD_SURR && (b1 & SURR_MASK) == SURR_MASK)
            lead_ok = 1'b0;
        else if ((b0 & MASK_3B) == MATCH_3B)
            need = 2'd2;
        else if ((b0 & MASK_4B) == MATCH_4B)
            need = 2'd3;
        else
            lead_ok = 1'b0;
    end

    assign seq_ok = lead_ok
                 && ((need < 2'd1) || c1)
                 && ((need < 2'd2) || c2)
                 && ((need < 2'd3) || c3);

    always_comb
    begin
        case (adv)
            3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: cp = {13'd0, b0};
        endcase
    end

    always_comb
    begin
        if (b0 == '0)
        begin
            res.codepoint     = '0;
            res.advance_width = 3'd1;
            res.decode_status = STATUS_END;
        end
        else if (!seq_ok)
        begin
            res.codepoint     = {13'd0, b0};
            res.advance_width = adv;
            res.decode_status = STATUS_RAW;
        end
        else
        begin
            res.codepoint     = cp;
            res.advance_width = adv;
            res.decode_status = STATUS_DECODED;
        end
    end

endmodule

// File: bench/tb_utf8_sequence_decode_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_sequence_decode_core
// self-checking bench for the utf8 sequence decode core
// ----------------------------------------------------------------------------
// A directed set of windows covers the lead classes, overlong forms,
// surrogates, bad leads, broken and truncated sequences and end of text.
// Random windows follow, mostly well-formed sequences with random content.
// Every offered window is decoded by a local predictor, and each result word
// is checked field by field against the oldest prediction. Both sides idle
// in random bursts. The receiver holds off once for a long stretch, and the
// sender drains the core once.
// ----------------------------------------------------------------------------
module tb_utf8_sequence_decode_core;

    import utf8sd_pkg::*;

    localparam int          RANDOM_ITEMS = 1700;
    localparam int          QUIET_TAIL   = 150;
    localparam int          HOLD_POINT   = 400;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_POINT  = 900;
    localparam int          END_SETTLE   = 8;
    localparam int          CYCLE_LIMIT  = 250000;
    localparam byte_t       ASCII_MAX    = 8'h7F;
    localparam byte_t       LEAD_4B_TOP  = 8'hF7;
    localparam byte_t       CONT_BITS    = 8'h3F;
    localparam byte_t       NUL          = 8'h00;
    localparam int unsigned BYTE_TOP     = 255;

    logic    clk           = 1'b0;
    logic    rst_n         = 1'b0;
    logic    item_valid    = 1'b0;
    logic    item_ready;
    byte_t   lead_byte     = '0;
    byte_t   second_byte   = '0;
    byte_t   third_byte    = '0;
    byte_t   fourth_byte   = '0;
    logic    result_valid;
    logic    result_ready  = 1'b0;
    cp_t     codepoint;
    adv_t    advance_width;
    status_t decode_status;

    window_t window_q[$];
    result_t decoded_q[$];

    int n_items      = 0;
    int offered      = 0;
    int gap_left     = 0;
    bit idle_on      = 1'b1;
    bit drain_hold   = 1'b0;
    int results_seen = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    bit stall_on     = 1'b1;
    int mon_cycles   = 0;
    int fail_count   = 0;
    int n_end        = 0;
    int n_decoded    = 0;
    int n_raw        = 0;
    int cycle_count  = 0;

    utf8_sequence_decode_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .lead_byte     (lead_byte),
        .second_byte   (second_byte),
        .third_byte    (third_byte),
        .fourth_byte   (fourth_byte),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .codepoint     (codepoint),
        .advance_width (advance_width),
        .decode_status (decode_status)
    );

    function automatic result_t decode_window(input window_t w);
        byte_t       b[4];
        int          ew;
        int          adv;
        int          need;
        bit          ok;
        bit          stop;
        int unsigned cp;
        result_t     r;
        b[0] = w.lead_byte;
        b[1] = w.second_byte;
        b[2] = w.third_byte;
        b[3] = w.fourth_byte;
        if (b[0] == NUL)
        begin
            r.codepoint     = '0;
            r.advance_width = ADV_W'(1);
            r.decode_status = STATUS_END;
            return r;
        end
        ew = 0;
        if (b[0] >= LEAD_2B_MIN && b[0] <= LEAD_2B_MAX)
            ew = 1;
        else if (b[0] >= LEAD_3B_MIN && b[0] <= LEAD_3B_MAX)
            ew = 2;
        else if (b[0] >= LEAD_4B_MIN && b[0] <= LEAD_4B_MAX)
            ew = 3;
        adv  = 1;
        stop = 1'b0;
        for (int i = 1; i <= ew; i++)
        begin
            if (b[i] == NUL)
                stop = 1'b1;
            if (!stop)
                adv++;
        end
        ok   = 1'b1;
        need = 0;
        if (b[0] <= ASCII_MAX)
            need = 0;
        else if ((b[0] & MASK_2B) == MATCH_2B)
            need = 1;
        else if (b[0] == LEAD_SURR && (b[1] & SURR_MASK) == SURR_MASK)
            ok = 1'b0;
        else if ((b[0] & MASK_3B) == MATCH_3B)
            need = 2;
        else if ((b[0] & MASK_4B) == MATCH_4B)
            need = 3;
        else
            ok = 1'b0;
        for (int i = 1; i <= need; i++)
            if ((b[i] & MASK_CONT) != MATCH_CONT)
                ok = 1'b0;
        r.advance_width = ADV_W'(adv);
        if (!ok)
        begin
            r.codepoint     = CP_W'(b[0]);
            r.decode_status = STATUS_RAW;
            return r;
        end
        if (adv == 1)
            cp = b[0];
        else
        begin
            cp = b[0] & (8'hFF >> (adv + 1));
            for (int i = 1; i < adv; i++)
                cp = (cp << 6) | (b[i] & CONT_BITS);
        end
        r.codepoint     = CP_W'(cp);
        r.decode_status = STATUS_DECODED;
        return r;
    endfunction

    function automatic byte_t rand_byte();
        return 8'($urandom_range(0, BYTE_TOP));
    endfunction

    function automatic byte_t rand_cont();
        return MATCH_CONT | 8'($urandom_range(0, CONT_BITS));
    endfunction

    function automatic window_t rand_window();
        window_t w;
        int      kind;
        int      pos;
        kind            = $urandom_range(0, 99);
        w.lead_byte     = rand_byte();
        w.second_byte   = rand_byte();
        w.third_byte    = rand_byte();
        w.fourth_byte   = rand_byte();
        if (kind < 10)
            return w;
        if (kind < 18)
            w.lead_byte = NUL;
        else if (kind < 30)
            w.lead_byte = 8'($urandom_range(1, ASCII_MAX));
        else if (kind < 45)
        begin
            w.lead_byte   = 8'($urandom_range(MATCH_2B, LEAD_2B_MAX));
            w.second_byte = rand_cont();
        end
        else if (kind < 63)
        begin
            w.lead_byte   = ($urandom_range(0, 2) == 0) ? LEAD_SURR :
                            8'($urandom_range(LEAD_3B_MIN, LEAD_3B_MAX));
            w.second_byte = rand_cont();
            w.third_byte  = rand_cont();
        end
        else if (kind < 80)
        begin
            w.lead_byte   = 8'($urandom_range(LEAD_4B_MIN, LEAD_4B_TOP));
            w.second_byte = rand_cont();
            w.third_byte  = rand_cont();
            w.fourth_byte = rand_cont();
        end
        else
        begin
            // multibyte-lead window of continuation bytes with one byte spoiled
            w.lead_byte   = 8'($urandom_range(MATCH_2B, LEAD_4B_TOP));
            w.second_byte = rand_cont();
            w.third_byte  = rand_cont();
            w.fourth_byte = rand_cont();
            pos           = $urandom_range(1, 3);
            case (pos)
                1: w.second_byte = (kind < 92) ? rand_byte() : NUL;
                2: w.third_byte  = (kind < 92) ? rand_byte() : NUL;
                default: w.fourth_byte = (kind < 92) ? rand_byte() : NUL;
            endcase
        end
        return w;
    endfunction

    task automatic add_window(input byte_t b0, input byte_t b1, input byte_t b2,
                              input byte_t b3);
        window_t w;
        w.lead_byte   = b0;
        w.second_byte = b1;
        w.third_byte  = b2;
        w.fourth_byte = b3;
        window_q.push_back(w);
    endtask

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                     results_seen, field, want, got);
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, decoded_q.size());
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin : drive_p
        window_t w;
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_ready)
        begin
            if (drain_hold && decoded_q.size() == 0)
                drain_hold = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (drain_hold || window_q.size() == 0)
                item_valid <= 1'b0;
            else if (idle_on && offered < n_items - QUIET_TAIL &&
                     $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(1, 15) - 1;
                item_valid <= 1'b0;
            end
            else
            begin
                w = window_q.pop_front();
                lead_byte   <= w.lead_byte;
                second_byte <= w.second_byte;
                third_byte  <= w.third_byte;
                fourth_byte <= w.fourth_byte;
                item_valid  <= 1'b1;
                decoded_q.push_back(decode_window(w));
                offered++;
                if (offered % 50 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                if (offered == DRAIN_POINT)
                    drain_hold = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_p
        result_t want;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (decoded_q.size() == 0)
                    report_mismatch("word with nothing awaited", 0, codepoint);
                else
                begin
                    want = decoded_q.pop_front();
                    if (codepoint !== want.codepoint)
                        report_mismatch("codepoint", want.codepoint, codepoint);
                    if (advance_width !== want.advance_width)
                        report_mismatch("advance_width", want.advance_width,
                                        advance_width);
                    if (decode_status !== want.decode_status)
                        report_mismatch("decode_status", want.decode_status,
                                        decode_status);
                    case (want.decode_status)
                        STATUS_END:     n_end++;
                        STATUS_DECODED: n_decoded++;
                        default:        n_raw++;
                    endcase
                end
            end
            mon_cycles++;
            if (mon_cycles % 64 == 0)
                stall_on = ($urandom_range(0, 3) != 0);
            if (!hold_done && results_seen >= HOLD_POINT)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (stall_on && results_seen < n_items - QUIET_TAIL &&
                     $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        // ascii, end of text and bad leads
        add_window(NUL, 8'h41, 8'h42, 8'h43);
        add_window(8'h01, NUL, NUL, NUL);
        add_window(ASCII_MAX, 8'hFF, 8'hFF, 8'hFF);
        add_window(8'h80, 8'h80, 8'h80, 8'h80);
        add_window(8'hBF, 8'hBF, 8'hBF, 8'hBF);
        add_window(8'hF8, 8'h80, 8'h80, 8'h80);
        add_window(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // two-byte leads, overlong c0 and c1
        add_window(8'hC0, 8'h80, NUL, NUL);
        add_window(8'hC1, 8'hBF, 8'hFF, 8'hFF);
        add_window(8'hC0, 8'h41, NUL, NUL);
        add_window(8'hC2, 8'h80, NUL, NUL);
        add_window(8'hDF, 8'hBF, 8'hBF, 8'hBF);
        add_window(8'hC2, NUL, 8'h80, 8'h80);
        add_window(8'hC2, 8'h41, NUL, NUL);
        // three-byte leads and surrogates
        add_window(8'hE0, 8'h80, 8'h80, NUL);
        add_window(8'hEF, 8'hBF, 8'hBF, 8'hFF);
        add_window(8'hED, 8'h9F, 8'hBF, NUL);
        add_window(8'hED, 8'hA0, 8'h80, NUL);
        add_window(8'hED, 8'hFF, 8'hBF, NUL);
        add_window(8'hE1, 8'h80, NUL, 8'h80);
        // four-byte leads, f5 to f7 and truncation
        add_window(8'hF0, 8'h80, 8'h80, 8'h80);
        add_window(8'hF4, 8'hBF, 8'hBF, 8'hBF);
        add_window(8'hF5, 8'h80, 8'h80, 8'h80);
        add_window(8'hF7, 8'hBF, 8'hBF, NUL);
        add_window(8'hF0, 8'h80, 8'h80, NUL);
        add_window(8'hF0, NUL, 8'h80, 8'h80);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            window_q.push_back(rand_window());
        n_items = window_q.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (window_q.size() != 0 || item_valid)
            @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);

        $display("%0d windows offered, %0d words checked: %0d end, %0d decoded, %0d raw",
                 offered, results_seen, n_end, n_decoded, n_raw);
        $display("receiver held off %0d cycles once, sender drained after window %0d",
                 LONG_HOLD, DRAIN_POINT);
        if (fail_count == 0 && decoded_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
